// ----- design/sha512_pkg.sv -----
package sha512_pkg;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
    } t_in_word;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_word;

    localparam logic [63:0] IV [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
        64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] PAD_WORD = 64'h8000000000000000;
    localparam int          ROUNDS   = 80;

    // round core control
    typedef struct packed {
        logic       start;
        logic [6:0] round;
    } t_core_ctl;

endpackage

// ----- design/sha512_core.sv -----
// one compression round per enabled cycle; 16-entry memory-free shift-line window
module sha512_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha512_pkg::t_core_ctl i_ctl,
    input  logic                  i_push,
    input  logic [63:0]           i_push_word,
    input  logic                  i_round_en,
    input  logic                  i_fold,
    input  logic                  i_reinit,
    output logic [63:0]           o_chain [8]
);
    logic [63:0] r_win [16];
    logic [63:0] r_v   [8];
    logic [63:0] r_chain [8];
    logic [63:0] w_new, w_cur, s0, s1, e_sig, a_sig, ch, mj, t1, t2;
    logic [63:0] x2, x15;

    always_comb begin
        x2    = r_win[14];
        x15   = r_win[1];
        s1    = {x2[18:0], x2[63:19]} ^ {x2[60:0], x2[63:61]} ^ (x2 >> 6);
        s0    = {x15[0], x15[63:1]} ^ {x15[7:0], x15[63:8]} ^ (x15 >> 7);
        w_new = s1 + r_win[9] + s0 + r_win[0];
        w_cur = (i_ctl.round < 7'd16) ? r_win[0] : w_new;
        e_sig = {r_v[4][13:0], r_v[4][63:14]} ^ {r_v[4][17:0], r_v[4][63:18]}
              ^ {r_v[4][40:0], r_v[4][63:41]};
        a_sig = {r_v[0][27:0], r_v[0][63:28]} ^ {r_v[0][33:0], r_v[0][63:34]}
              ^ {r_v[0][38:0], r_v[0][63:39]};
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + e_sig + ch + sha512_pkg::ROUND_K[i_ctl.round] + w_cur;
        t2    = a_sig + mj;
    end

    // window is a shift line: entry 0 is the oldest word, new words enter at 15
    always_ff @(posedge i_clk) begin
        if (i_push || i_round_en) begin
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
            r_win[15] <= i_push ? i_push_word : w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= sha512_pkg::IV[i];
                r_v[i]     <= '0;
            end
        end else if (i_reinit) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= sha512_pkg::IV[i];
        end else if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
        end else if (i_round_en) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else if (i_fold) begin
            for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + r_v[i];
        end
    end

    assign o_chain = r_chain;
endmodule

// ----- design/sha512_message_hasher.sv -----
// channel | direction | payload                | handshake
// in      | input     | t_in_word  (i_in_word)  | i_in_valid / o_in_stall
// out     | output    | t_out_word (o_out_word) | o_out_valid / i_out_stall
// a plain word is only pushed; the sixteenth of a block also starts a compression
// (load, 80 rounds on the shared round unit, fold into chain state)
// a last word pushes padding one word per cycle and compresses one or two more blocks,
// then shows eight digest words, one per accepted output cycle
// synchronous active-low reset restores the initial chain state
// i_out_stall holds the current digest word; input stays stalled until all are taken
module sha512_message_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sha512_pkg::t_in_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sha512_pkg::t_out_word o_out_word
);
    localparam logic [2:0] S_IDLE = 3'd0, S_LOAD = 3'd1, S_ROUND = 3'd2,
                           S_FOLD = 3'd3, S_PAD = 3'd4, S_OUT = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_pos;
    logic [6:0]  r_round;
    logic [63:0] r_bytes;
    logic        r_padding;   // message finished, padding in progress
    logic [1:0]  r_pad_ph;    // 0 pad word, 1 zero fill, 2 length hi, 3 length lo
    logic [2:0]  r_out_idx;
    logic [63:0] chain [8];
    sha512_pkg::t_core_ctl ctl;
    logic        push, round_en, fold, reinit;
    logic [63:0] push_word;
    logic        in_acc;
    logic [3:0]  n_eff;
    logic [63:0] kept, mask;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign n_eff      = (i_in_word.byte_count > 4'd8) ? 4'd8 : i_in_word.byte_count;
    assign mask       = ~(64'hFFFFFFFFFFFFFFFF >> {n_eff, 3'b000});
    assign kept       = (i_in_word.data_word & mask)
                      | ((n_eff == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {n_eff, 3'b000})));

    always_comb begin
        push      = 1'b0;
        push_word = '0;
        if (r_state == S_IDLE && in_acc) begin
            push = 1'b1;
            push_word = i_in_word.last ? kept : i_in_word.data_word;
        end else if (r_state == S_PAD) begin
            push = 1'b1;
            case (r_pad_ph)
                2'd0:    push_word = sha512_pkg::PAD_WORD;
                2'd1:    push_word = '0;
                2'd2:    push_word = {3'b000, r_bytes[63:3]} >> 58;
                default: push_word = {r_bytes[60:0], 3'b000};
            endcase
        end
        round_en  = (r_state == S_ROUND);
        fold      = (r_state == S_FOLD);
        reinit    = (r_state == S_OUT) && !i_out_stall && (r_out_idx == 3'd7);
        ctl.start = (r_state == S_LOAD);
        ctl.round = r_round;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) begin
                if (r_pos == 4'd15) n_state = S_LOAD;
                else if (i_in_word.last) n_state = S_PAD;
            end
            S_PAD:   if (r_pos == 4'd15) n_state = S_LOAD;
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: if (r_round == 7'(sha512_pkg::ROUNDS - 1)) n_state = S_FOLD;
            S_FOLD:  n_state = r_padding ? ((r_pad_ph == 2'd3 && r_pos == 4'd0) ? S_OUT : S_PAD)
                                         : S_IDLE;
            S_OUT:   if (!i_out_stall && r_out_idx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_round   <= '0;
            r_bytes   <= '0;
            r_padding <= 1'b0;
            r_pad_ph  <= '0;
            r_out_idx <= '0;
        end else begin
            r_state <= n_state;
            if (push) r_pos <= r_pos + 4'd1;
            if (r_state == S_ROUND) r_round <= r_round + 7'd1;
            else r_round <= '0;
            if (r_state == S_IDLE && in_acc) begin
                r_bytes <= r_bytes + (i_in_word.last ? 64'(n_eff) : 64'd8);
                if (i_in_word.last) begin
                    r_padding <= 1'b1;
                    // partial word already carries the pad byte
                    // entering zero fill already at slot 14 goes straight to the length
                    if (n_eff == 4'd8) r_pad_ph <= 2'd0;
                    else if (r_pos == 4'd13) r_pad_ph <= 2'd2;
                    else r_pad_ph <= 2'd1;
                end
            end
            if (r_state == S_PAD) begin
                case (r_pad_ph)
                    2'd0:    r_pad_ph <= (r_pos == 4'd13) ? 2'd2 : 2'd1;
                    2'd1:    if (r_pos == 4'd13) r_pad_ph <= 2'd2;
                    2'd2:    r_pad_ph <= 2'd3;
                    default: r_pad_ph <= 2'd3;
                endcase
            end
            if (r_state == S_OUT && !i_out_stall) begin
                r_out_idx <= r_out_idx + 3'd1;
                if (r_out_idx == 3'd7) begin
                    r_padding <= 1'b0;
                    r_bytes   <= '0;
                    r_pad_ph  <= '0;
                end
            end
        end
    end

    sha512_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_push     (push),
        .i_push_word(push_word),
        .i_round_en (round_en),
        .i_fold     (fold),
        .i_reinit   (reinit),
        .o_chain    (chain)
    );

    assign o_out_valid            = (r_state == S_OUT);
    assign o_out_word.digest_word = chain[r_out_idx];
    assign o_out_word.word_index  = r_out_idx;
    assign o_out_word.last_word   = (r_out_idx == 3'd7);

    a_no_in_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall) else $error("input taken while busy");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round < 7'd80)) else $error("round overrun");
    a_out_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (r_out_idx == 3'd0 && r_pos == 4'd0))
        else $error("digest not aligned");
    a_fold_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> $past(r_state == S_ROUND)) else $error("fold out of order");
endmodule

// ----- test/sha512_message_hasher_tb.sv -----
module sha512_message_hasher_tb;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    sha512_pkg::t_in_word  i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    sha512_pkg::t_out_word o_out_word;

    sha512_message_hasher u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // predictor state
    logic [63:0] chain_q [8];
    logic [63:0] blk_words [16];
    logic [3:0]  blk_pos;
    logic [63:0] msg_bytes;
    sha512_pkg::t_out_word digest_q [$];
    int          n_fail;
    int          send_idle_pct;
    int          recv_stall_pct;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_blk();
        logic [63:0] a, b, c, d, e, f, g, h, w, t1, t2, x2, x15;
        logic [63:0] sched [16];
        sched = blk_words;
        {a, b, c, d} = {chain_q[0], chain_q[1], chain_q[2], chain_q[3]};
        {e, f, g, h} = {chain_q[4], chain_q[5], chain_q[6], chain_q[7]};
        for (int t = 0; t < sha512_pkg::ROUNDS; t++) begin
            if (t < 16) begin
                w = sched[t];
            end else begin
                x2  = sched[(t - 2) & 15];
                x15 = sched[(t - 15) & 15];
                w = (ror64(x2, 19) ^ ror64(x2, 61) ^ (x2 >> 6)) + sched[(t - 7) & 15]
                  + (ror64(x15, 1) ^ ror64(x15, 8) ^ (x15 >> 7)) + sched[t & 15];
                sched[t & 15] = w;
            end
            t1 = h + (ror64(e, 14) ^ ror64(e, 18) ^ ror64(e, 41)) + ((e & f) ^ (~e & g))
               + sha512_pkg::ROUND_K[t] + w;
            t2 = (ror64(a, 28) ^ ror64(a, 34) ^ ror64(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
        chain_q[4] += e; chain_q[5] += f; chain_q[6] += g; chain_q[7] += h;
    endtask

    task automatic load_word(logic [63:0] w);
        blk_words[blk_pos] = w;
        blk_pos = blk_pos + 4'd1;
        if (blk_pos == 4'd0)
            compress_blk();
    endtask

    task automatic hash_word(sha512_pkg::t_in_word iw);
        int          n;
        logic [63:0] kept;
        sha512_pkg::t_out_word dw;
        if (!iw.last) begin
            msg_bytes += 64'd8;
            load_word(iw.data_word);
            return;
        end
        n = (iw.byte_count > 8) ? 8 : int'(iw.byte_count);
        msg_bytes += 64'(n);
        if (n == 8) begin
            load_word(iw.data_word);
            load_word(sha512_pkg::PAD_WORD);
        end else begin
            kept = (n == 0) ? 64'd0 : (iw.data_word & ~({64{1'b1}} >> (8 * n)));
            load_word(kept | (64'h80 << (56 - 8 * n)));
        end
        while (blk_pos != 4'd14)
            load_word(64'd0);
        load_word(msg_bytes >> 61);
        load_word(msg_bytes << 3);
        for (int i = 0; i < 8; i++) begin
            dw.digest_word = chain_q[i];
            dw.word_index  = 3'(i);
            dw.last_word   = (i == 7);
            digest_q.push_back(dw);
            chain_q[i] = sha512_pkg::IV[i];
        end
        msg_bytes = 0;
        blk_pos   = 0;
    endtask

    // output side: random stall, compare on accept
    always @(posedge i_clk) begin
        sha512_pkg::t_out_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_out_word);
                n_fail++;
            end else begin
                exp_w = digest_q.pop_front();
                if (o_out_word !== exp_w) begin
                    $display("%0t: expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                             exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                             o_out_word.digest_word, o_out_word.word_index,
                             o_out_word.last_word);
                    n_fail++;
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);

    // called at a falling edge; valid stays up after the word is taken until
    // the next word or an idle cycle replaces it
    task automatic send_word(sha512_pkg::t_in_word iw);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= iw;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        hash_word(iw);
        @(negedge i_clk);
    endtask

    function automatic sha512_pkg::t_in_word mk_word(logic [63:0] d, logic [3:0] bc, logic l);
        sha512_pkg::t_in_word iw;
        iw.data_word  = d;
        iw.byte_count = bc;
        iw.last       = l;
        return iw;
    endfunction

    // directed rows: data, byte count, last
    typedef struct {
        logic [63:0] data;
        logic [3:0]  bc;
        logic        last;
    } t_row;

    localparam int N_ROWS = 22;
    t_row dir_rows [N_ROWS] = '{
        '{64'h0, 4'd0, 1'b1},                              // empty message
        '{64'h6162630000000000, 4'd3, 1'b1},               // "abc"
        '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1},
        '{64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1},              // count above 8
        '{64'hFFFFFFFFFFFFFFFF, 4'd1, 1'b1},
        '{64'hA5A5A5A5A5A5A5A5, 4'd7, 1'b1},
        '{64'h0123456789ABCDEF, 4'd15, 1'b0},              // count ignored when not last
        '{64'hFEDCBA9876543210, 4'd0, 1'b0},
        '{64'h0, 4'd9, 1'b1},
        '{64'hFFFFFFFFFFFFFFFF, 4'd4, 1'b0},
        '{64'h5A5A5A5A5A5A5A5A, 4'd2, 1'b1},
        '{64'h1, 4'd5, 1'b1},
        '{64'h8000000000000000, 4'd6, 1'b1},
        '{64'h0, 4'd8, 1'b0}, '{64'h0, 4'd8, 1'b0}, '{64'h0, 4'd8, 1'b0},
        '{64'h0, 4'd8, 1'b0}, '{64'h0, 4'd8, 1'b0}, '{64'h0, 4'd8, 1'b0},
        '{64'h0, 4'd8, 1'b0}, '{64'h0, 4'd8, 1'b0},
        '{64'h1111111111111111, 4'd8, 1'b1}
    };

    task automatic send_msg(int n_words);
        logic [3:0] bc;
        for (int i = 0; i < n_words - 1; i++)
            send_word(mk_word({$urandom, $urandom}, 4'($urandom), 1'b0));
        bc = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        send_word(mk_word({$urandom, $urandom}, bc, 1'b1));
    endtask

    initial begin
        n_fail         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        i_out_stall    = 1'b0;
        for (int i = 0; i < 8; i++)
            chain_q[i] = sha512_pkg::IV[i];
        blk_pos   = 0;
        msg_bytes = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the empty-message and "abc" digests open with the well-known A words
        for (int r = 0; r < N_ROWS; r++) begin
            send_word(mk_word(dir_rows[r].data, dir_rows[r].bc, dir_rows[r].last));
            if (r == 0 && digest_q[0].digest_word !== 64'hcf83e1357eefb8bd) begin
                $display("%0t: expected cf83e1357eefb8bd actual %h", $time,
                         digest_q[0].digest_word);
                n_fail++;
            end
            if (r == 1 && digest_q[$ - 7].digest_word !== 64'hddaf35a193617aba) begin
                $display("%0t: expected ddaf35a193617aba actual %h", $time,
                         digest_q[$ - 7].digest_word);
                n_fail++;
            end
        end

        // random messages over phases of input idling and output stall; mostly short, some past a block
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                3: begin send_idle_pct = 25; recv_stall_pct = 25; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int m = 0; m < 12; m++)
                send_msg(($urandom_range(4) == 0) ? $urandom_range(14, 34)
                                                  : $urandom_range(1, 4));
        end
        i_in_valid <= 1'b0;

        while (digest_q.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
